@@ hw/rtl/cac_pkg.sv @@
`default_nettype none

package cac_pkg;

   localparam int TIME_BITS = 32;
   localparam int TEMP_BITS = 12;
   localparam int MOIST_BITS = 10;
   localparam int HOUR_BITS = 5;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int NUM_TIMED = 3;
   localparam int NUM_DEVICES = 4;

   typedef enum logic [1:0] {
      OP_SENSOR = 2'd0,
      OP_BEGIN  = 2'd1,
      OP_TOGGLE = 2'd2,
      OP_MANUAL = 2'd3
   } cac_opcode_type;

   typedef enum logic [1:0] {
      MODE_INITIAL  = 2'd0,
      MODE_ACTIVE   = 2'd1,
      MODE_OVERRIDE = 2'd2
   } cac_mode_type;

   typedef enum logic [1:0] {
      DEV_FAN    = 2'd0,
      DEV_HEATER = 2'd1,
      DEV_PUMP   = 2'd2,
      DEV_LIGHT  = 2'd3
   } cac_device_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TEMP_UPPER     = 3'd0,
      CSR_TEMP_LOWER     = 3'd1,
      CSR_MOIST_THRESH   = 3'd2,
      CSR_TOGGLE_DELAY   = 3'd3,
      CSR_OPERATION_TIME = 3'd4,
      CSR_LIGHTS_ON      = 3'd5,
      CSR_LIGHTS_OFF     = 3'd6
   } cac_csr_type;

   typedef struct packed {
      logic [1:0]                  opcode;
      logic signed [TEMP_BITS-1:0] temperature;
      logic [MOIST_BITS-1:0]       moisture;
      logic [HOUR_BITS-1:0]        hour_of_day;
      logic [TIME_BITS-1:0]        now_ms;
      logic [1:0]                  device_select;
      logic                        device_value;
   } cac_req_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       fan_on;
      logic       heater_on;
      logic       pump_on;
      logic       light_on;
   } cac_rsp_type;

   // Per-item control for one timed actuator.
   typedef struct packed {
      logic drive;
      logic want;
      logic manual_set;
      logic manual_value;
   } cac_act_ctrl_type;

endpackage

`default_nettype wire

@@ hw/rtl/cac_timed_actuator.sv @@
`default_nettype none

module cac_timed_actuator
   import cac_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cac_act_ctrl_type     ctrl,
   input  wire logic [TIME_BITS-1:0] now_ms,
   input  wire logic [TIME_BITS-1:0] toggle_delay_ms,
   input  wire logic [TIME_BITS-1:0] operation_time_ms,
   output logic                      on_next,
   output logic                      on
);

   logic                 on_ff, on_in;
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic [TIME_BITS-1:0] elapsed;
   logic                 switch_on, switch_off;

   // Wraparound subtraction gives the elapsed time modulo 2^TIME_BITS.
   assign elapsed    = now_ms - last_ff;
   assign switch_on  = ctrl.drive && ctrl.want && !on_ff && (elapsed > toggle_delay_ms);
   assign switch_off = ctrl.drive && !ctrl.want && on_ff && (elapsed > operation_time_ms);

   always_comb begin
      on_in   = on_ff;
      last_in = last_ff;
      if (ctrl.manual_set) begin
         on_in = ctrl.manual_value;
      end else if (switch_on || switch_off) begin
         on_in   = switch_on;
         last_in = now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff   <= 1'b0;
         last_ff <= '0;
      end else begin
         on_ff   <= on_in;
         last_ff <= last_in;
      end
   end

   assign on_next = on_in;
   assign on      = on_ff;

endmodule

`default_nettype wire

@@ hw/rtl/climate_actuator_controller_top.sv @@
// Climate actuator controller. One request beat is taken per clock while req_stall is low;
// its result beat is registered in the response register, or in the skid register behind a
// stalled response. A full update (mode, holds, the three timed actuators and the light) is
// one pass of compares and 32-bit wraparound subtractions on the state registers, so the
// sustained rate is one beat per cycle while rsp_stall is low. A two-entry output stage
// (response register plus skid register) lets a request be taken while a finished response
// is still stalled; req_stall rises only when both are full. The register port is always
// ready (csr_ready is tied high) and its writes should only be made while no response is outstanding.
`default_nettype none

module climate_actuator_controller_top
   import cac_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire cac_req_type               req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output cac_rsp_type                    rsp_payload,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // Configuration registers.
   logic signed [TEMP_BITS-1:0] temp_upper_ff, temp_lower_ff;
   logic [MOIST_BITS-1:0]       moist_thresh_ff;
   logic [TIME_BITS-1:0]        toggle_delay_ff, operation_time_ff;
   logic [HOUR_BITS-1:0]        lights_on_ff, lights_off_ff;
   logic                        csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_upper_ff     <= TEMP_BITS'(300);
         temp_lower_ff     <= TEMP_BITS'(180);
         moist_thresh_ff   <= MOIST_BITS'(400);
         toggle_delay_ff   <= TIME_BITS'(5000);
         operation_time_ff <= TIME_BITS'(60000);
         lights_on_ff      <= HOUR_BITS'(6);
         lights_off_ff     <= HOUR_BITS'(22);
      end else if (csr_fire) begin
         unique case (csr_index)
            CSR_TEMP_UPPER:     temp_upper_ff     <= csr_wdata[TEMP_BITS-1:0];
            CSR_TEMP_LOWER:     temp_lower_ff     <= csr_wdata[TEMP_BITS-1:0];
            CSR_MOIST_THRESH:   moist_thresh_ff   <= csr_wdata[MOIST_BITS-1:0];
            CSR_TOGGLE_DELAY:   toggle_delay_ff   <= csr_wdata[TIME_BITS-1:0];
            CSR_OPERATION_TIME: operation_time_ff <= csr_wdata[TIME_BITS-1:0];
            CSR_LIGHTS_ON:      lights_on_ff      <= csr_wdata[HOUR_BITS-1:0];
            CSR_LIGHTS_OFF:     lights_off_ff     <= csr_wdata[HOUR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Handshake and output stage.
   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   cac_rsp_type out_ff, out_in;
   cac_rsp_type skid_ff, skid_in;
   cac_rsp_type new_rsp;
   logic        req_fire, rsp_fire;

   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_fire) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = new_rsp;
            out_valid_in = req_fire;
         end
      end else if (req_fire) begin
         skid_in       = new_rsp;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // Mode state machine.
   cac_mode_type   mode_ff, mode_in;
   cac_opcode_type opcode;
   cac_device_type device;
   logic           clear_held, sensor_go, manual_go;

   assign opcode = cac_opcode_type'(req_payload.opcode);
   assign device = cac_device_type'(req_payload.device_select);

   always_comb begin
      mode_in = mode_ff;
      if (req_fire) begin
         unique case (opcode)
            OP_BEGIN:  mode_in = MODE_ACTIVE;
            OP_TOGGLE: mode_in = (mode_ff == MODE_OVERRIDE) ? MODE_ACTIVE : MODE_OVERRIDE;
            default:   mode_in = mode_ff;
         endcase
      end
   end

   always_comb begin
      clear_held = 1'b0;
      sensor_go  = 1'b0;
      manual_go  = 1'b0;
      if (req_fire) begin
         unique case (opcode)
            OP_SENSOR: sensor_go = (mode_ff != MODE_INITIAL);
            OP_BEGIN, OP_TOGGLE: clear_held = (mode_ff == MODE_OVERRIDE);
            OP_MANUAL: manual_go = (mode_ff == MODE_OVERRIDE);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_INITIAL;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Manual holds, one per device.
   logic [NUM_DEVICES-1:0] held_ff, held_in;

   always_comb begin
      held_in = held_ff;
      if (clear_held) begin
         held_in = '0;
      end else if (manual_go) begin
         held_in[device] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   // Timed actuators: fan, heater, pump.
   cac_act_ctrl_type       act_ctrl [NUM_TIMED];
   logic [NUM_TIMED-1:0]   act_want;
   logic [NUM_TIMED-1:0]   act_on_next, act_on;

   assign act_want[DEV_FAN]    = req_payload.temperature > temp_upper_ff;
   assign act_want[DEV_HEATER] = req_payload.temperature < temp_lower_ff;
   assign act_want[DEV_PUMP]   = req_payload.moisture < moist_thresh_ff;

   for (genvar i = 0; i < NUM_TIMED; i++) begin : g_timed
      always_comb begin
         act_ctrl[i].drive        = sensor_go && !held_ff[i];
         act_ctrl[i].want         = act_want[i];
         act_ctrl[i].manual_set   = manual_go && (device == cac_device_type'(i));
         act_ctrl[i].manual_value = req_payload.device_value;
      end

      cac_timed_actuator u_actuator (
         .clock             (clock),
         .reset             (reset),
         .ctrl              (act_ctrl[i]),
         .now_ms            (req_payload.now_ms),
         .toggle_delay_ms   (toggle_delay_ff),
         .operation_time_ms (operation_time_ff),
         .on_next           (act_on_next[i]),
         .on                (act_on[i])
      );
   end

   // Grow light follows the hour window; an on hour at or above the off hour wraps.
   logic light_ff, light_in, in_window;

   always_comb begin
      if (lights_on_ff < lights_off_ff) begin
         in_window = (req_payload.hour_of_day >= lights_on_ff) &&
                     (req_payload.hour_of_day < lights_off_ff);
      end else begin
         in_window = (req_payload.hour_of_day >= lights_on_ff) ||
                     (req_payload.hour_of_day < lights_off_ff);
      end
   end

   always_comb begin
      light_in = light_ff;
      if (manual_go && device == DEV_LIGHT) begin
         light_in = req_payload.device_value;
      end else if (sensor_go && !held_ff[DEV_LIGHT]) begin
         light_in = in_window;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff <= 1'b0;
      end else begin
         light_ff <= light_in;
      end
   end

   always_comb begin
      new_rsp.mode      = mode_in;
      new_rsp.fan_on    = act_on_next[DEV_FAN];
      new_rsp.heater_on = act_on_next[DEV_HEATER];
      new_rsp.pump_on   = act_on_next[DEV_PUMP];
      new_rsp.light_on  = light_in;
   end

   // The skid register only fills behind a response that is still waiting.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid register full while response register is empty");

   // Holds exist only while in override mode.
   a_held_only_override: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_OVERRIDE) |-> (held_ff == '0))
      else $error("manual hold present outside override mode");

   // Nothing can switch on before the first begin or toggle.
   a_initial_all_off: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_INITIAL) |-> (act_on == '0 && !light_ff))
      else $error("actuator on while in initial mode");

   // A response beat reports the mode that the block held after its request.
   a_rsp_mode_tracks: assert property (@(posedge clock) disable iff (reset)
      (req_fire && out_valid_in && !skid_valid_ff && (!out_valid_ff || rsp_fire))
      |=> (rsp_payload.mode == mode_ff))
      else $error("response mode differs from controller mode");

endmodule

`default_nettype wire
